// ===== rtl/kwa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwa_pkg
// Shared types and constants of the keyed weighted average table.
// ----------------------------------------------------------------------------
package kwa_pkg;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 24;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_SET    = 3'd1,
    CMD_ZERO   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_CALC   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic [KEY_W-1:0]           key;
    logic [WEIGHT_W-1:0]        weight;
    logic signed [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic                       ok;
    logic signed [VALUE_W-1:0]  average;
    logic [COUNT_W-1:0]         entry_count;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/kwa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/keyed_weighted_average_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Operation: append, set value, zero values and clear write the result register
//   at the accepting edge, and it moves on to a free output register; calculate
//   reads the RAMs once per key, drains the multiply and accumulate stages, loads
//   the divider, then runs a 41 + log2(KEYS) step restoring divide; zero weight skips it.
// Flow: input stalls while busy or while the result register is full; it reopens
//   once the result moves to the output register. Reset clears table and control.
// ----------------------------------------------------------------------------
// keyed_weighted_average_table
// Keyed table of weights and values with a weighted mean over valid entries.
// ----------------------------------------------------------------------------
module keyed_weighted_average_table #(
  parameter int KEYS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire kwa_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output kwa_pkg::out_t     out_data
);

  localparam int AW     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CNT_W  = $clog2(KEYS + 1);
  localparam int PROD_W = kwa_pkg::VALUE_W + kwa_pkg::WEIGHT_W + 1;
  localparam int ACC_W  = PROD_W + AW;
  localparam int WSUM_W = kwa_pkg::WEIGHT_W + AW;
  localparam int DIV_CW = $clog2(ACC_W + 1);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  kwa_pkg::state_t state_r, state_nxt;

  logic [KEYS-1:0]  valid_r;   // entry holds a key
  logic [KEYS-1:0]  vzero_r;   // entry value reads as zero until set again
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  kwa_pkg::out_t res_r, out_r;
  logic          res_valid_r, out_valid_r;

  // sweep and divider
  logic [AW-1:0]             idx_r;
  logic                      p1_v_r, p2_v_r;
  logic [AW-1:0]             p1_idx_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [kwa_pkg::WEIGHT_W-1:0] wgt_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [WSUM_W-1:0]         wsum_r;
  logic                      neg_r;
  logic [ACC_W-1:0]          quo_r;
  logic [WSUM_W-1:0]         rem_r;
  logic [DIV_CW-1:0]         dcnt_r;

  // --------------------------------------------------------------------------
  // Input decode. Accept only in idle with the result stage empty; the output
  // register still lets a finished result wait while the next one is built.
  // --------------------------------------------------------------------------
  logic          in_acc;
  logic [AW-1:0] key_idx;
  logic          in_range, present;
  logic          cmd_ok, do_append, do_set, do_zero, do_clear, do_calc;

  assign in_stall = (state_r != kwa_pkg::ST_IDLE) || res_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign key_idx  = AW'(in_data.key);
  assign in_range = 32'(in_data.key) < 32'(KEYS);
  assign present  = in_range && valid_r[key_idx];

  always_comb begin
    cmd_ok    = 1'b0;
    do_append = 1'b0;
    do_set    = 1'b0;
    do_zero   = 1'b0;
    do_clear  = 1'b0;
    do_calc   = 1'b0;
    unique case (in_data.command)
      kwa_pkg::CMD_APPEND: begin
        cmd_ok    = in_range && !present;
        do_append = cmd_ok;
      end
      kwa_pkg::CMD_SET: begin
        cmd_ok = present;
        do_set = present;
      end
      kwa_pkg::CMD_ZERO: begin
        cmd_ok  = 1'b1;
        do_zero = 1'b1;
      end
      kwa_pkg::CMD_CLEAR: begin
        cmd_ok   = 1'b1;
        do_clear = 1'b1;
      end
      kwa_pkg::CMD_CALC: begin
        cmd_ok  = 1'b1;
        do_calc = 1'b1;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_append) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_clear) begin
      cnt_nxt = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Weight and value memories. Append writes the weight and marks the value
  // zero; set value writes the value. The sweep reads both at idx_r.
  // --------------------------------------------------------------------------
  logic                         rd_en;
  logic [kwa_pkg::WEIGHT_W-1:0] w_rd;
  logic [kwa_pkg::VALUE_W-1:0]  v_rd;

  kwa_ram #(
    .WIDTH (kwa_pkg::WEIGHT_W),
    .DEPTH (KEYS)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (in_acc && do_append),
    .wr_addr (key_idx),
    .wr_data (in_data.weight),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (w_rd)
  );

  kwa_ram #(
    .WIDTH (kwa_pkg::VALUE_W),
    .DEPTH (KEYS)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (in_acc && do_set),
    .wr_addr (key_idx),
    .wr_data (in_data.value),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (v_rd)
  );

  // --------------------------------------------------------------------------
  // State machine: next state
  // --------------------------------------------------------------------------
  logic sweep_last, drain_done, div_last;

  assign sweep_last = (idx_r == AW'(KEYS - 1));
  assign drain_done = !p1_v_r && !p2_v_r;
  assign div_last   = (dcnt_r == DIV_CW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kwa_pkg::ST_IDLE: begin
        if (in_acc && do_calc) begin
          state_nxt = kwa_pkg::ST_SWEEP;
        end
      end
      kwa_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = kwa_pkg::ST_DRAIN;
        end
      end
      kwa_pkg::ST_DRAIN: begin
        if (drain_done) begin
          // zero total weight skips the divide and yields zero
          state_nxt = (wsum_r == '0) ? kwa_pkg::ST_FIN : kwa_pkg::ST_DIV;
        end
      end
      kwa_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = kwa_pkg::ST_FIN;
        end
      end
      kwa_pkg::ST_FIN: begin
        state_nxt = kwa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kwa_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State machine: outputs
  // --------------------------------------------------------------------------
  logic div_load, div_step, fin;

  always_comb begin
    rd_en    = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    fin      = 1'b0;
    unique case (state_r)
      kwa_pkg::ST_IDLE:  rd_en    = 1'b0;
      kwa_pkg::ST_SWEEP: rd_en    = 1'b1;
      kwa_pkg::ST_DRAIN: div_load = drain_done;
      kwa_pkg::ST_DIV:   div_step = 1'b1;
      kwa_pkg::ST_FIN:   fin      = 1'b1;
      default:           rd_en    = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Multiply stage: one entry per cycle, taking the registered RAM read data.
  // Drop invalid entries; a value marked zero contributes weight only.
  // --------------------------------------------------------------------------
  logic signed [kwa_pkg::VALUE_W-1:0] v_eff;
  logic signed [PROD_W-1:0]           prod;
  logic                               p1_hit;

  assign p1_hit = valid_r[p1_idx_r];
  assign v_eff  = vzero_r[p1_idx_r] ? '0 : $signed(v_rd);
  assign prod   = v_eff * $signed({1'b0, w_rd});

  // --------------------------------------------------------------------------
  // Divider step: restoring, one quotient bit per cycle on magnitudes
  // --------------------------------------------------------------------------
  logic [WSUM_W:0]                    rem_sh, diff;
  logic                               ge;
  logic [ACC_W-1:0]                   acc_mag;
  logic [kwa_pkg::VALUE_W-1:0]        q_mag;
  logic [kwa_pkg::VALUE_W-1:0]        avg;

  assign rem_sh  = {rem_r, quo_r[ACC_W-1]};
  assign diff    = rem_sh - {1'b0, wsum_r};
  assign ge      = !diff[WSUM_W];
  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  // the mean lies within the value range, so the quotient fits in 24 bits
  assign q_mag   = quo_r[kwa_pkg::VALUE_W-1:0];
  assign avg     = neg_r ? (~q_mag + kwa_pkg::VALUE_W'(1)) : q_mag;

  // --------------------------------------------------------------------------
  // Result and output stages
  // --------------------------------------------------------------------------
  logic res_set, out_load;

  assign res_set  = (in_acc && !do_calc) || fin;
  assign out_load = res_valid_r && (!out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kwa_pkg::ST_IDLE;
      valid_r     <= '0;
      vzero_r     <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      idx_r       <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= in_acc ? cnt_nxt : cnt_r;

      if (in_acc) begin
        if (do_append) begin
          valid_r[key_idx] <= 1'b1;
          vzero_r[key_idx] <= 1'b1;
        end
        if (do_set) begin
          vzero_r[key_idx] <= 1'b0;
        end
        if (do_zero) begin
          vzero_r <= '1;
        end
        if (do_clear) begin
          valid_r <= '0;
        end
      end

      // advance the sweep index and the pipeline marks
      if (in_acc && do_calc) begin
        idx_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + AW'(1);
      end
      p1_v_r <= rd_en;
      p2_v_r <= p1_v_r;

      if (div_load) begin
        dcnt_r <= DIV_CW'(ACC_W);
      end else if (div_step) begin
        dcnt_r <= dcnt_r - DIV_CW'(1);
      end

      if (res_set) begin
        res_valid_r <= 1'b1;
      end else if (out_load) begin
        res_valid_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    p1_idx_r <= idx_r;

    if (p1_v_r) begin
      prod_r <= p1_hit ? prod : '0;
      wgt_r  <= p1_hit ? w_rd : '0;
    end

    // clear the sums on a new calculate, accumulate behind the multiplier
    if (in_acc && do_calc) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (p2_v_r) begin
      acc_r  <= acc_r + ACC_W'(prod_r);
      wsum_r <= wsum_r + WSUM_W'(wgt_r);
    end

    if (div_load) begin
      neg_r <= acc_r[ACC_W-1];
      quo_r <= (wsum_r == '0) ? '0 : acc_mag;
      rem_r <= '0;
    end else if (div_step) begin
      rem_r <= ge ? diff[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
      quo_r <= {quo_r[ACC_W-2:0], ge};
    end

    if (in_acc && !do_calc) begin
      res_r.ok          <= cmd_ok;
      res_r.average     <= '0;
      res_r.entry_count <= kwa_pkg::COUNT_W'(cnt_nxt);
    end else if (fin) begin
      res_r.ok          <= 1'b1;
      res_r.average     <= avg;
      res_r.entry_count <= kwa_pkg::COUNT_W'(cnt_r);
    end

    if (out_load) begin
      out_r <= res_r;
    end
  end

endmodule
`default_nettype wire
